@@ design/fnms_pkg.sv @@
// ----------------------------------------------------------------------------
// fnms_pkg
// Shared types and constants of the four-neighbor mean smoother.
// ----------------------------------------------------------------------------
package fnms_pkg;

	localparam int PIX_W    = 8;
	localparam int MAX_COLS = 2048;
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int CFG_W    = 12;
	localparam int ROW_W    = 12;
	localparam int SUM_W    = PIX_W + 2;

	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;
	localparam int ADDR_LSB = 2;
	localparam int IDX_W    = APB_AW - ADDR_LSB;

	localparam logic [IDX_W-1:0] REG_COLS = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_ROWS = IDX_W'(1);

	localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(1080);
	localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(1920);
	localparam logic [CFG_W-1:0] MIN_COLS   = CFG_W'(3);
	localparam logic [CFG_W-1:0] MIN_ROWS   = CFG_W'(2);
	localparam logic [CFG_W-1:0] COLS_CAP   = CFG_W'(MAX_COLS);

	typedef struct packed {
		logic [PIX_W-1:0] pixel_in;
		logic             flush;
	} pix_req_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             row_end;
		logic             frame_end;
	} pix_res_t;

	// frame geometry after clamping
	typedef struct packed {
		logic [CFG_W-1:0] cols;
		logic [CFG_W-1:0] rows;
	} geom_t;

endpackage

@@ design/fnms_ram.sv @@
// ----------------------------------------------------------------------------
// fnms_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fnms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/fnms_cfg.sv @@
// ----------------------------------------------------------------------------
// fnms_cfg
// APB register file: row length and frame height, clamped to legal geometry.
// ----------------------------------------------------------------------------
module fnms_cfg import fnms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output geom_t             geom
);

	logic [CFG_W-1:0] cols_q;
	logic [CFG_W-1:0] rows_q;
	logic [IDX_W-1:0] idx;
	logic             wr;

	assign idx = paddr[APB_AW-1:ADDR_LSB];
	assign wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
		end else if (wr) begin
			case (idx)
				REG_COLS: cols_q <= pwdata[CFG_W-1:0];
				REG_ROWS: rows_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_COLS: prdata = APB_DW'(cols_q);
			REG_ROWS: prdata = APB_DW'(rows_q);
			default:  prdata = '0;
		endcase
	end

	always_comb begin
		if (cols_q < MIN_COLS) begin
			geom.cols = MIN_COLS;
		end else if (cols_q > COLS_CAP) begin
			geom.cols = COLS_CAP;
		end else begin
			geom.cols = cols_q;
		end
		geom.rows = (rows_q < MIN_ROWS) ? MIN_ROWS : rows_q;
	end

endmodule

@@ design/four_neighbour_mean_smoother.sv @@
// ----------------------------------------------------------------------------
// four_neighbour_mean_smoother
// Recursive four-neighbor mean smoothing of a row-major pixel stream.
// ----------------------------------------------------------------------------
// Accepts one request per clock unless the result side stalls; results,
// registered in stage 1 and at the output, trail the input by one image row,
// and after the last row the caller sends one flush request per column to
// drain it. Two 2048 x 8 line stores (originals and smoothed pixels) are
// each read once and written at most once per pixel; the right-hand original
// read ahead is reused as the next column's center, and column 0 of the row
// above is held in a register. The stores need no clearing pass after reset.
module four_neighbour_mean_smoother import fnms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	input  logic              pix_valid,
	output logic              pix_ready,
	input  pix_req_t          pix_data,
	output logic              res_valid,
	input  logic              res_ready,
	output pix_res_t          res_data
);

	geom_t geom;

	fnms_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.geom    (geom)
	);

	assign pready = 1'b1;

	// front end: position counters
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             in_flush;
	logic             last_col;
	logic             interior;
	logic             accept;
	logic             eff;

	// stage 1
	logic             s1_valid_q;
	logic [PIX_W-1:0] pix_s1;
	logic [COL_W-1:0] col_s1;
	logic             flush_s1;
	logic             prod_s1;
	logic             inner_s1;
	logic             row_end_s1;
	logic             frame_end_s1;
	logic             s1_go;

	logic [PIX_W-1:0] left_q;
	logic [PIX_W-1:0] right_q;
	logic [PIX_W-1:0] first_q;
	logic [PIX_W-1:0] center;
	logic [PIX_W-1:0] orig_rdata;
	logic [PIX_W-1:0] smooth_rdata;
	logic [SUM_W-1:0] sum;
	logic [PIX_W-1:0] res;

	logic     out_valid_q;
	pix_res_t out_q;

	assign in_flush = row_q >= geom.rows;
	assign last_col = (CFG_W'(col_q) + CFG_W'(1)) >= geom.cols;
	assign interior = (row_q >= ROW_W'(2)) && (col_q != '0) && !last_col;

	assign s1_go     = s1_valid_q && (!prod_s1 || !out_valid_q || res_ready);
	assign pix_ready = !s1_valid_q || s1_go;
	assign accept    = pix_valid && pix_ready;
	assign eff       = accept && (pix_data.flush == in_flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (eff) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= in_flush ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	fnms_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_COLS)
	) u_orig_ram (
		.clk   (clk),
		.we    (eff && !in_flush),
		.waddr (col_q),
		.wdata (pix_data.pixel_in),
		.re    (eff),
		.raddr (col_q + COL_W'(1)),
		.rdata (orig_rdata)
	);

	fnms_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_COLS)
	) u_smooth_ram (
		.clk   (clk),
		.we    (s1_go && prod_s1),
		.waddr (col_s1),
		.wdata (res),
		.re    (eff),
		.raddr (col_q),
		.rdata (smooth_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (eff) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eff) begin
			pix_s1       <= pix_data.pixel_in;
			col_s1       <= col_q;
			flush_s1     <= in_flush;
			prod_s1      <= in_flush || (row_q != '0);
			inner_s1     <= interior && !in_flush;
			row_end_s1   <= last_col;
			frame_end_s1 <= in_flush && last_col;
		end
	end

	assign center = (col_s1 == '0) ? first_q : right_q;
	assign sum    = SUM_W'(smooth_rdata) + SUM_W'(left_q) + SUM_W'(orig_rdata)
	              + SUM_W'(pix_s1);
	assign res    = inner_s1 ? sum[SUM_W-1:2] : center;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (s1_go) begin
			left_q <= center;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			right_q <= orig_rdata;
			if (col_s1 == '0 && !flush_s1) begin
				first_q <= pix_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && prod_s1) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && prod_s1) begin
			out_q.pixel_out <= res;
			out_q.row_end   <= row_end_s1;
			out_q.frame_end <= frame_end_s1;
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	// assertions
	a_frame_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!res_data.frame_end || res_data.row_end))
		else $error("frame end without row end");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(eff && in_flush && last_col) |=> (row_q == '0 && col_q == '0))
		else $error("position did not return to frame start");

	a_stall_holds_read: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_go) |=> ((orig_rdata === $past(orig_rdata))
		&& (smooth_rdata === $past(smooth_rdata))))
		else $error("line store data changed under a stalled request");

	a_no_accept_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_go) |-> !eff)
		else $error("request taken while stage 1 is stalled");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-neighbor mean smoother.
// ----------------------------------------------------------------------------
// Streams row-major frames of many geometries through the pixel port. Gaps on
// the request side and stalls on the result side are random. Every accepted
// request feeds a line-buffer predictor that keeps its own copy of the
// geometry registers. Each result is compared field by field with the oldest
// predicted one. Geometry changes go through the APB port only while the
// smoother is idle, mostly at frame boundaries and sometimes inside a frame.
// ----------------------------------------------------------------------------
module testbench;
	import fnms_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE      = 8;

	class smoother_scoreboard;
		logic [CFG_W-1:0] cols_reg;
		logic [CFG_W-1:0] rows_reg;
		logic [PIX_W-1:0] orig_line [MAX_COLS];
		logic [PIX_W-1:0] smooth_line [MAX_COLS];
		logic [PIX_W-1:0] left_px;
		logic [PIX_W-1:0] center_px;
		int unsigned      col_pos;
		int unsigned      row_pos;
		pix_res_t         expected_q [$];
		int               errors;
		int               n_pixels;
		int               n_ignored;
		int               n_results;

		function new();
			cols_reg = COLS_RESET;
			rows_reg = ROWS_RESET;
			foreach (orig_line[i]) begin
				orig_line[i]   = '0;
				smooth_line[i] = '0;
			end
			left_px   = '0;
			center_px = '0;
			col_pos   = 0;
			row_pos   = 0;
			errors    = 0;
			n_pixels  = 0;
			n_ignored = 0;
			n_results = 0;
		endfunction

		function int unsigned line_len();
			if (cols_reg < MIN_COLS) return MIN_COLS;
			if (cols_reg > COLS_CAP) return COLS_CAP;
			return cols_reg;
		endfunction

		function int unsigned frame_rows();
			return (rows_reg < MIN_ROWS) ? MIN_ROWS : rows_reg;
		endfunction

		function bit draining();
			return row_pos >= frame_rows();
		endfunction

		function bit at_frame_start();
			return row_pos == 0 && col_pos == 0;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == REG_COLS) cols_reg = val;
			else if (idx == REG_ROWS) rows_reg = val;
		endfunction

		// returns 0 when the smoother drops the request
		function bit note_request(pix_req_t req);
			bit          last_col;
			bit          flushing;
			int unsigned sum;
			pix_res_t    want;
			last_col = (col_pos + 1 >= line_len());
			flushing = draining();
			if (req.flush != flushing) begin
				n_ignored++;
				return 0;
			end
			center_px      = orig_line[col_pos];
			want.pixel_out = center_px;
			if (!flushing && row_pos >= 2 && col_pos >= 1 && !last_col) begin
				sum = 32'(smooth_line[col_pos]) + 32'(left_px) +
				      32'(orig_line[col_pos + 1]) + 32'(req.pixel_in);
				want.pixel_out = PIX_W'(sum >> 2);
			end
			want.row_end   = last_col;
			want.frame_end = flushing && last_col;
			if (flushing || row_pos >= 1) begin
				smooth_line[col_pos] = want.pixel_out;
				expected_q.push_back(want);
			end
			if (!flushing) orig_line[col_pos] = req.pixel_in;
			left_px = center_px;
			if (last_col) begin
				col_pos = 0;
				row_pos = flushing ? 0 : ((row_pos + 1) & 12'hFFF);
			end else begin
				col_pos = (col_pos + 1) & 11'h7FF;
			end
			n_pixels++;
			return 1;
		endfunction

		function void check_result(pix_res_t got);
			pix_res_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected result: pixel_out %0d row_end %0b frame_end %0b",
				       got.pixel_out, got.row_end, got.frame_end);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			n_results++;
			if (got.pixel_out !== want.pixel_out) begin
				$error("pixel_out: expected %0d, got %0d", want.pixel_out, got.pixel_out);
				errors++;
			end
			if (got.row_end !== want.row_end) begin
				$error("row_end: expected %0b, got %0b", want.row_end, got.row_end);
				errors++;
			end
			if (got.frame_end !== want.frame_end) begin
				$error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
				errors++;
			end
		endfunction
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [APB_AW-1:0] paddr     = '0;
	logic [APB_DW-1:0] pwdata    = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              pix_valid = 1'b0;
	logic              pix_ready;
	pix_req_t          pix_data  = '0;
	logic              res_valid;
	logic              res_ready = 1'b1;
	pix_res_t          res_data;

	smoother_scoreboard sb = new();
	bit                 calm        = 1'b0;
	int                 px_mode     = 3;
	int                 ready_left  = 0;
	int                 idle_cycles = 0;
	int                 n_frames    = 0;
	int                 n_writes    = 0;

	four_neighbour_mean_smoother dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_data  (pix_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int roll;
		if (calm) return 0;
		roll = $urandom_range(0, 31);
		if (roll < 18) return 0;
		if (roll < 29) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [PIX_W-1:0] next_pixel();
		case (px_mode)
			0: return '0;
			1: return '1;
			2: return $urandom_range(0, 1) ? '1 : '0;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pix_req_t mk_req(logic [PIX_W-1:0] px, logic fl);
		pix_req_t req;
		req.pixel_in = px;
		req.flush    = fl;
		return req;
	endfunction

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) sb.check_result(res_data);
		if (ready_left > 0) begin
			ready_left <= ready_left - 1;
		end else if (calm || !res_ready) begin
			res_ready  <= 1'b1;
			ready_left <= $urandom_range(0, 12);
		end else begin
			res_ready  <= 1'b0;
			ready_left <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if ((pix_valid && pix_ready) || (res_valid && res_ready) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_request(input pix_req_t req, output bit counted);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix_data  <= req;
		@(posedge clk);
		while (!pix_ready) @(posedge clk);
		counted = sb.note_request(req);
	endtask

	// write, then read back over APB
	task automatic reg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		logic [APB_DW-1:0] back;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(idx) << ADDR_LSB;
		pwdata  <= APB_DW'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, val);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		back = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (back[CFG_W-1:0] !== val) begin
			$error("%s readback: expected %0d, got %0d",
			       (idx == REG_COLS) ? "cols_in_use" : "rows_in_use", val, back[CFG_W-1:0]);
			sb.errors++;
		end
		n_writes++;
	endtask

	// drop valid, wait out all results plus the pipeline tail
	task automatic drain_pipeline();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// finish the current frame; optionally change geometry after cut_at pixels
	task automatic run_frame(int cut_at);
		pix_req_t req;
		int       n;
		int       cut;
		bit       counted;
		bit       done;
		n    = 0;
		cut  = cut_at;
		done = 1'b0;
		while (!done) begin
			if (n == cut) begin
				cut = -1;
				drain_pipeline();
				if ($urandom_range(0, 1))
					reg_write(REG_COLS, CFG_W'($urandom_range(0, sb.line_len())));
				else
					reg_write(REG_ROWS, CFG_W'($urandom_range(0, sb.row_pos + 3)));
			end
			req.flush = sb.draining();
			if ($urandom_range(0, 19) == 0) req.flush = !req.flush;
			req.pixel_in = next_pixel();
			send_request(req, counted);
			if (counted) begin
				n++;
				done = sb.at_frame_start();
			end
		end
		n_frames++;
	endtask

	initial begin
		bit counted;
		int i;
		int roll;
		int rnd_start;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 3x3 clamped frame of saturated pixels, plus requests that get dropped
		calm = 1'b1;
		reg_write(REG_COLS, CFG_W'(0));
		reg_write(REG_ROWS, CFG_W'(3));
		send_request(mk_req(8'h5A, 1'b1), counted);
		for (i = 0; i < 9; i++) send_request(mk_req(8'hFF, 1'b0), counted);
		send_request(mk_req(8'h00, 1'b0), counted);
		for (i = 0; i < 3; i++) send_request(mk_req(8'h00, 1'b1), counted);
		drain_pipeline();

		// both registers below their minimum
		reg_write(REG_COLS, CFG_W'(2));
		reg_write(REG_ROWS, CFG_W'(1));
		for (i = 0; i < 6; i++) send_request(mk_req((i % 2) ? 8'hFF : 8'h00, 1'b0), counted);
		for (i = 0; i < 3; i++) send_request(mk_req(8'hA5, 1'b1), counted);
		drain_pipeline();
		calm = 1'b0;

		// tallest frame, cut into the drain by a rows write
		px_mode = 3;
		reg_write(REG_COLS, CFG_W'(3));
		reg_write(REG_ROWS, 12'hFFF);
		for (i = 0; i < 12; i++) send_request(mk_req(next_pixel(), 1'b0), counted);
		drain_pipeline();
		reg_write(REG_ROWS, CFG_W'(0));
		run_frame(-1);
		drain_pipeline();

		// oversize row length clamps to the line store; the row is cut short
		reg_write(REG_COLS, 12'hFFF);
		reg_write(REG_ROWS, CFG_W'(2));
		for (i = 0; i < 10; i++) send_request(mk_req(next_pixel(), 1'b0), counted);
		drain_pipeline();
		reg_write(REG_COLS, CFG_W'(3));
		run_frame(-1);
		drain_pipeline();
		reg_write(REG_COLS, CFG_W'(5));

		rnd_start = sb.n_pixels;
		while (sb.n_pixels - rnd_start < 500) begin
			calm    = ($urandom_range(0, 3) == 0);
			px_mode = $urandom_range(0, 7);
			if ($urandom_range(0, 3) != 0) begin
				roll = $urandom_range(0, 9);
				if (roll == 0) reg_write(REG_COLS, CFG_W'($urandom_range(0, 2)));
				else if (roll == 1) reg_write(REG_COLS, CFG_W'($urandom_range(20, 64)));
				else reg_write(REG_COLS, CFG_W'($urandom_range(3, 10)));
			end
			if ($urandom_range(0, 3) != 0) begin
				if ($urandom_range(0, 9) == 0) reg_write(REG_ROWS, CFG_W'($urandom_range(0, 1)));
				else reg_write(REG_ROWS, CFG_W'($urandom_range(2, 7)));
			end
			if ($urandom_range(0, 4) == 0)
				run_frame($urandom_range(1, sb.line_len() * sb.frame_rows()));
			else
				run_frame(-1);
			drain_pipeline();
		end
		calm = 1'b0;
		drain_pipeline();

		$display("Covered %0d frames: %0d requests (%0d dropped), %0d results, %0d reg writes",
		         n_frames, sb.n_pixels, sb.n_ignored, sb.n_results, n_writes);
		$display("Rows of 3 to 64 pixels plus an oversize one, up to 4095 rows, mid-frame changes");
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ sim.f @@
design/fnms_pkg.sv
design/fnms_ram.sv
design/fnms_cfg.sv
design/four_neighbour_mean_smoother.sv
bench/testbench.sv
